// ----- rtl/core/lesf_pkg.sv -----
// shared constants and types for the largest empty square finder
// no dependencies
package lesf_pkg;

  localparam int unsigned DEF_MAX_SIDE = 1024;
  localparam int unsigned QUEUE_DEPTH  = 4;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned SIDE_W = 11;
  localparam int unsigned POS_W  = 10;

  localparam logic [CHAR_W-1:0] EMPTY_CHAR = 8'h2E;
  localparam logic [CHAR_W-1:0] BLOCK_CHAR = 8'h6F;

  localparam logic [SIDE_W-1:0] GRID_SIDE_RST = 11'd1024;

  typedef struct packed {
    logic vld;
    logic empty;
  } cell_req_t;

endpackage

// ----- rtl/core/lesf_front.sv -----
// front end: accepts map bytes, drops anything but cells, queues cell requests
// depends on lesf_pkg
module lesf_front
  import lesf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_map_char,
  output cell_req_t         req,
  input  logic              req_pop
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [QUEUE_DEPTH-1:0] slot_r;
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   is_cell;
  logic                   push;
  logic                   pop;

  always_comb begin
    is_cell = in_map_char inside {EMPTY_CHAR, BLOCK_CHAR};
  end

  assign in_stall = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && !in_stall && is_cell;
  assign pop      = req_pop && (cnt_r != '0);

  assign req.vld   = (cnt_r != '0);
  assign req.empty = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= (in_map_char == EMPTY_CHAR);
    end
  end

endmodule

// ----- rtl/core/lesf_back.sv -----
// back end: square dynamic programming over one line buffer, best tracking,
// grid side register and output register; depends on lesf_pkg
module lesf_back
  import lesf_pkg::*;
#(
  parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIDE_W-1:0] cfg_data,
  input  cell_req_t         req,
  output logic              req_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIDE_W-1:0] out_cell_square,
  output logic              out_grid_done,
  output logic [SIDE_W-1:0] out_best_side,
  output logic [POS_W-1:0]  out_best_row,
  output logic [POS_W-1:0]  out_best_col
);

  localparam int unsigned CW = $clog2(MAX_SIDE);
  localparam int unsigned VW = $clog2(MAX_SIDE + 1);

  logic [VW-1:0]     line_mem [MAX_SIDE];
  logic [VW-1:0]     up_rd_r;

  logic [SIDE_W-1:0] grid_side_r;
  logic [CW-1:0]     col_r, col_nxt;
  logic [CW-1:0]     row_r, row_nxt;
  logic [VW-1:0]     left_r, left_nxt;
  logic [VW-1:0]     diag_r, diag_nxt;
  logic [VW-1:0]     best_r, best_nxt;
  logic [CW-1:0]     best_row_r, best_row_nxt;
  logic [CW-1:0]     best_col_r, best_col_nxt;

  logic              out_valid_r;
  logic [SIDE_W-1:0] cell_square_r;
  logic              grid_done_r;
  logic [SIDE_W-1:0] best_side_r;
  logic [POS_W-1:0]  best_row_out_r;
  logic [POS_W-1:0]  best_col_out_r;

  logic [VW-1:0]     side_m1;
  logic [VW-1:0]     up;
  logic [VW-1:0]     least;
  logic [VW-1:0]     v;
  logic              last;
  logic              row_end;

  // grid side in use, held to 1..MAX_SIDE
  always_comb begin
    if (grid_side_r == '0) begin
      side_m1 = '0;
    end else if (32'(grid_side_r) > MAX_SIDE) begin
      side_m1 = VW'(MAX_SIDE - 1);
    end else begin
      side_m1 = VW'(grid_side_r) - 1'b1;
    end
  end

  assign req_pop = req.vld && (!out_valid_r || !out_stall);

  always_comb begin
    up = (row_r != '0) ? up_rd_r : '0;
    least = left_r;
    if (up < least) begin
      least = up;
    end
    if (diag_r < least) begin
      least = diag_r;
    end
    if (!req.empty) begin
      v = '0;
    end else if (row_r == '0 || col_r == '0) begin
      v = VW'(1);
    end else begin
      v = least + 1'b1;
    end
    row_end = (VW'(col_r) == side_m1);
    last    = row_end && (VW'(row_r) == side_m1);
  end

  always_comb begin
    best_nxt     = best_r;
    best_row_nxt = best_row_r;
    best_col_nxt = best_col_r;
    if (v > best_r) begin
      best_nxt     = v;
      best_row_nxt = row_r;
      best_col_nxt = col_r;
    end
  end

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    diag_nxt = diag_r;
    if (cfg_we) begin
      col_nxt  = '0;
      row_nxt  = '0;
      left_nxt = '0;
      diag_nxt = '0;
    end else if (req_pop) begin
      if (last) begin
        col_nxt  = '0;
        row_nxt  = '0;
        left_nxt = '0;
        diag_nxt = '0;
      end else if (row_end) begin
        col_nxt  = '0;
        row_nxt  = row_r + 1'b1;
        left_nxt = '0;
        diag_nxt = '0;
      end else begin
        col_nxt  = col_r + 1'b1;
        left_nxt = v;
        diag_nxt = up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= GRID_SIDE_RST;
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      diag_r      <= '0;
      best_r      <= '0;
      best_row_r  <= '0;
      best_col_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
      diag_r <= diag_nxt;
      if (cfg_we) begin
        grid_side_r <= cfg_data;
        best_r      <= '0;
        best_row_r  <= '0;
        best_col_r  <= '0;
      end else if (req_pop) begin
        if (last) begin
          best_r     <= '0;
          best_row_r <= '0;
          best_col_r <= '0;
        end else begin
          best_r     <= best_nxt;
          best_row_r <= best_row_nxt;
          best_col_r <= best_col_nxt;
        end
      end
      if (req_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // line buffer: the next column is fetched while the current one is written
  always_ff @(posedge clk) begin
    if (req_pop) begin
      line_mem[col_r] <= v;
    end
    up_rd_r <= line_mem[col_nxt];
  end

  always_ff @(posedge clk) begin
    if (req_pop) begin
      cell_square_r  <= SIDE_W'(v);
      grid_done_r    <= last;
      best_side_r    <= SIDE_W'(best_nxt);
      best_row_out_r <= POS_W'(best_row_nxt);
      best_col_out_r <= POS_W'(best_col_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_cell_square = cell_square_r;
  assign out_grid_done   = grid_done_r;
  assign out_best_side   = best_side_r;
  assign out_best_row    = best_row_out_r;
  assign out_best_col    = best_col_out_r;

endmodule

// ----- rtl/core/largest_empty_square_finder_top.sv -----
// channel   direction  handshake          payload
// in        input      in_valid/in_stall   in_map_char
// out       output     out_valid/out_stall out_cell_square, out_grid_done, out_best_*
// cfg       input      cfg_we              cfg_data (grid side)
//
// one map byte per cycle while in_stall is low; a cell passes the front queue, then the output register
// the single line buffer takes one write per cell and reads the next column in that cycle
// bytes other than cells are taken and dropped in the front end
// the four-request front queue lets input flow while out_stall is high until it fills
// reset is synchronous; the line buffer needs no clearing pass
// top level of the largest empty square finder; depends on lesf_pkg,
// lesf_front and lesf_back
module largest_empty_square_finder_top
  import lesf_pkg::*;
#(
  parameter int unsigned MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [SIDE_W-1:0] cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAR_W-1:0] in_map_char,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIDE_W-1:0] out_cell_square,
  output logic              out_grid_done,
  output logic [SIDE_W-1:0] out_best_side,
  output logic [POS_W-1:0]  out_best_row,
  output logic [POS_W-1:0]  out_best_col
);

  cell_req_t req;
  logic      req_pop;

  lesf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_map_char (in_map_char),
    .req         (req),
    .req_pop     (req_pop)
  );

  lesf_back #(
    .MAX_SIDE (MAX_SIDE)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .req             (req),
    .req_pop         (req_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_square (out_cell_square),
    .out_grid_done   (out_grid_done),
    .out_best_side   (out_best_side),
    .out_best_row    (out_best_row),
    .out_best_col    (out_best_col)
  );

endmodule
